// ===== hw/rtl/lzssd_pkg.sv =====
// Shared types and codes for the LZSS stream decoder.
package lzssd_pkg;

  // Tokens governed by one flag byte
  localparam int GROUP_SIZE = 8;

  // Input actions
  localparam logic [1:0] ACT_FEED    = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_NONE    = 3'd1;
  localparam logic [2:0] ST_IDLE    = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_BAD_OFS = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       copy_pending;
  } out_item_t;

  // Per-beat control handed from the parser to the data stage
  typedef struct packed {
    logic       emit;       // a byte is produced and written to history
    logic       from_hist;  // produced byte comes from the history read
    logic [2:0] status;
    logic       pending;    // copy still pending after this beat
    logic [7:0] lit;        // literal byte
  } tok_ctl_t;

endpackage

// ===== hw/rtl/lzss_stream_decoder.sv =====
// Top level of the LZSS stream decoder: handshakes, data stage and result register.
//
// Streaming LZSS decoder taking one beat per clock while the output is not stalled:
// a compressed byte to feed, a tick that emits the next byte of a pending copy, or a
// restart. Every beat yields exactly one result beat, passing through the data stage
// and the result register. Sustained rate is one beat per cycle when the output is
// not stalled, including back-to-back ticks of an overlapping copy with offset one;
// this is set by the history memory, which has one write and one read port: the
// parser issues the copy read in the accept cycle, and the following data stage
// writes the produced byte back, forwarding it to a read taken in the same edge. The
// history memory needs no clearing after reset; bytes never written are never read.
module lzss_stream_decoder import lzssd_pkg::*; #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int PW = $clog2(HISTORY_DEPTH + 1);

  logic          acc;
  tok_ctl_t      ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    hist_rd;
  logic [7:0]    wr_data;
  logic          wr_en;

  logic          s1_v_r;
  tok_ctl_t      s1_ctl_r;
  logic [AW-1:0] s1_wa_r;
  logic          s1_adv;

  logic          out_v_r;
  out_item_t     out_data_r;

  // Handshakes: data stage moves on whenever the result register is free
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign acc      = in_valid && in_ready;

  lzssd_parser #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW),
    .PW            (PW)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .item    (in_data),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  // Produced byte is written back as the beat leaves the data stage
  assign wr_data = s1_ctl_r.from_hist ? hist_rd : s1_ctl_r.lit;
  assign wr_en   = s1_adv && s1_ctl_r.emit;

  lzssd_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW)
  ) u_history (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc && ctl.from_hist),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_wa_r),
    .wr_data (wr_data),
    .rd_data (hist_rd)
  );

  // Data stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  // Data stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r <= ctl;
      s1_wa_r  <= wr_addr;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.out_byte     <= s1_ctl_r.emit ? wr_data : 8'd0;
      out_data_r.status       <= s1_ctl_r.status;
      out_data_r.copy_pending <= s1_ctl_r.pending;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Only byte beats carry data
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_BYTE) |-> out_data.out_byte == 8'd0)
    else $error("non-byte result carries data");

  // A history write goes with a byte status and vice versa
  a_emit_status: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_ctl_r.emit == (s1_ctl_r.status == ST_BYTE)))
    else $error("emit flag and status disagree");

  // A new beat never overwrites a beat still held in the data stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    acc && s1_v_r |-> s1_adv)
    else $error("data stage overrun");

  // An accepted beat is held in the data stage in the next cycle when the result register is free
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (!out_v_r || out_ready) |=> s1_v_r)
    else $error("accepted beat lost");
`endif

endmodule

// ===== hw/rtl/lzssd_parser.sv =====
// Token parser: flag groups, match tokens, copy counter and history pointers.
module lzssd_parser import lzssd_pkg::*; #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int AW            = $clog2(HISTORY_DEPTH),
  parameter int PW            = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  in_item_t      item,
  output tok_ctl_t      ctl,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);

  localparam int CW = AW + 1;
  localparam int OW = 17;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [3:0]    gbi_r, gbi_nxt;
  logic [1:0]    tbi_r, tbi_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [15:0]   rem_r, rem_nxt;

  logic          busy;
  logic          bad_ofs;
  logic [CW-1:0] src_sum;
  logic [AW-1:0] wp_inc;
  logic [PW-1:0] prod_inc;

  // Copy source: write pointer minus offset, wrapped into the store
  always_comb begin
    src_sum = CW'(wp_r) + CW'(HISTORY_DEPTH) - CW'(off_r);
    if (src_sum >= CW'(HISTORY_DEPTH)) begin
      src_sum = src_sum - CW'(HISTORY_DEPTH);
    end
    rd_addr = src_sum[AW-1:0];
  end

  assign wr_addr  = wp_r;
  assign busy     = (tbi_r == 2'd0) && (rem_r != 16'd0);
  assign bad_ofs  = (off_r == 16'd0) || (OW'(off_r) > OW'(prod_r));
  assign wp_inc   = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign prod_inc = (prod_r < PW'(HISTORY_DEPTH)) ? prod_r + PW'(1) : prod_r;

  // Next-state and beat control
  always_comb begin
    wp_nxt    = wp_r;
    prod_nxt  = prod_r;
    flags_nxt = flags_r;
    gbi_nxt   = gbi_r;
    tbi_nxt   = tbi_r;
    off_nxt   = off_r;
    rem_nxt   = rem_r;
    ctl        = '0;
    ctl.status = ST_IDLE;
    ctl.lit    = item.in_byte;

    case (item.action)
      ACT_FEED: begin
        if (busy) begin
          ctl.status = ST_BUSY;
        end else if (gbi_r >= 4'(GROUP_SIZE)) begin
          // new flag byte
          flags_nxt  = item.in_byte;
          gbi_nxt    = 4'd0;
          ctl.status = ST_NONE;
        end else if (!flags_r[gbi_r[2:0]]) begin
          // literal
          ctl.emit   = 1'b1;
          ctl.status = ST_BYTE;
          wp_nxt     = wp_inc;
          prod_nxt   = prod_inc;
          gbi_nxt    = gbi_r + 4'd1;
        end else begin
          ctl.status = ST_NONE;
          case (tbi_r)
            2'd0: begin
              off_nxt = {item.in_byte, 8'h00};
              tbi_nxt = 2'd1;
            end
            2'd1: begin
              off_nxt = {off_r[15:8], item.in_byte};
              tbi_nxt = 2'd2;
            end
            2'd2: begin
              rem_nxt = {item.in_byte, 8'h00};
              tbi_nxt = 2'd3;
            end
            default: begin
              // last token byte: length low, offset check
              tbi_nxt = 2'd0;
              gbi_nxt = gbi_r + 4'd1;
              if (bad_ofs) begin
                rem_nxt    = 16'd0;
                ctl.status = ST_BAD_OFS;
              end else begin
                rem_nxt = {rem_r[15:8], item.in_byte};
              end
            end
          endcase
        end
      end
      ACT_TICK: begin
        if (busy) begin
          ctl.emit      = 1'b1;
          ctl.from_hist = 1'b1;
          ctl.status    = ST_BYTE;
          wp_nxt        = wp_inc;
          prod_nxt      = prod_inc;
          rem_nxt       = rem_r - 16'd1;
        end
      end
      ACT_RESTART: begin
        wp_nxt     = '0;
        prod_nxt   = '0;
        flags_nxt  = 8'd0;
        gbi_nxt    = 4'(GROUP_SIZE);
        tbi_nxt    = 2'd0;
        off_nxt    = 16'd0;
        rem_nxt    = 16'd0;
        ctl.status = ST_NONE;
      end
      default: begin
        ctl.status = ST_IDLE;
      end
    endcase

    ctl.pending = (tbi_nxt == 2'd0) && (rem_nxt != 16'd0);
  end

  // Parser state, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      prod_r  <= '0;
      flags_r <= 8'd0;
      gbi_r   <= 4'(GROUP_SIZE);
      tbi_r   <= 2'd0;
      off_r   <= 16'd0;
      rem_r   <= 16'd0;
    end else if (acc) begin
      wp_r    <= wp_nxt;
      prod_r  <= prod_nxt;
      flags_r <= flags_nxt;
      gbi_r   <= gbi_nxt;
      tbi_r   <= tbi_nxt;
      off_r   <= off_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ===== hw/rtl/lzssd_history.sv =====
// History store: one write and one registered read port, with write-to-read forwarding.
module lzssd_history import lzssd_pkg::*; #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int AW            = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] q_r;
  logic [7:0] fwd_data_r;
  logic       fwd_r;

  // Memory array: read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Capture a write that lands in the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

// ===== dv/tb_lzss_stream_decoder.sv =====
// Self-checking testbench for the LZSS stream decoder: directed table, then random streams.
module tb_lzss_stream_decoder;
  import lzssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HISTORY_DEPTH = 65536;
  localparam int NUM_DIR       = 28;
  localparam int PHASE_A_BEATS = 350;
  localparam int TOTAL_BEATS   = 700;
  localparam int DRAIN_CYCLES  = 16;
  localparam int EXP_DEPTH     = 16;
  localparam longint CYCLE_LIMIT = 20_000_000;

  // Action code the block treats as an idle tick
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  typedef struct {
    in_item_t  beat;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  lzss_stream_decoder #(.HISTORY_DEPTH(HISTORY_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state as predicted
  logic [7:0]  hist_mem [HISTORY_DEPTH];
  logic [15:0] wr_pos;
  logic [16:0] produced_cnt;
  logic [7:0]  grp_flags;
  logic [3:0]  grp_idx;
  logic [1:0]  tok_idx;
  logic [15:0] ofs_hold;
  logic [15:0] copy_rem;

  // Token under construction by the stream generator
  logic [15:0] tok_ofs;
  logic [15:0] tok_len;

  // Expected result beats in flight, oldest at exp_rd
  out_item_t   exp_fifo [EXP_DEPTH];
  int          exp_wr;
  int          exp_rd;
  int          exp_cnt;
  out_item_t   pred;
  out_item_t   want;
  bit          exp_fixed;
  out_item_t   exp_want;
  bit          in_taken;
  bit          in_calm;
  bit          out_calm;
  int          stall_left;
  longint      cycle_count;
  int          errors;
  int          beats_in;
  int          results_seen;
  int          copy_bytes;
  int          bad_ofs_cnt;
  int          busy_cnt;

  function automatic bit copy_busy();
    return tok_idx == 2'd0 && copy_rem != 16'd0;
  endfunction

  function automatic void clear_stream();
    wr_pos       = '0;
    produced_cnt = '0;
    grp_flags    = '0;
    grp_idx      = 4'(GROUP_SIZE);
    tok_idx      = '0;
    ofs_hold     = '0;
    copy_rem     = '0;
  endfunction

  // Every produced byte lands in the history window
  function automatic void put_history(input logic [7:0] b);
    hist_mem[wr_pos] = b;
    wr_pos           = wr_pos + 16'd1;
    if (produced_cnt < 17'(HISTORY_DEPTH)) produced_cnt = produced_cnt + 17'd1;
  endfunction

  // Expected result beat for one accepted input beat; advances the state
  function automatic out_item_t lzss_decode_beat(input in_item_t it);
    out_item_t   r;
    logic [7:0]  b;
    logic [15:0] len;
    r = '0;
    case (it.action)
      ACT_FEED: begin
        if (copy_busy()) begin
          r.status = ST_BUSY;
        end else if (grp_idx >= 4'(GROUP_SIZE)) begin
          grp_flags = it.in_byte;
          grp_idx   = '0;
          r.status  = ST_NONE;
        end else if (!grp_flags[grp_idx[2:0]]) begin
          put_history(it.in_byte);
          grp_idx    = grp_idx + 4'd1;
          r.out_byte = it.in_byte;
          r.status   = ST_BYTE;
        end else begin
          r.status = ST_NONE;
          case (tok_idx)
            2'd0: begin
              ofs_hold = {it.in_byte, 8'h00};
              tok_idx  = 2'd1;
            end
            2'd1: begin
              ofs_hold[7:0] = it.in_byte;
              tok_idx       = 2'd2;
            end
            2'd2: begin
              copy_rem = {it.in_byte, 8'h00};
              tok_idx  = 2'd3;
            end
            default: begin
              len     = {copy_rem[15:8], it.in_byte};
              tok_idx = 2'd0;
              grp_idx = grp_idx + 4'd1;
              // zero offset, or reaching back past what has been produced
              if (ofs_hold == 16'd0 || 17'(ofs_hold) > produced_cnt) begin
                copy_rem = '0;
                r.status = ST_BAD_OFS;
              end else begin
                copy_rem = len;
              end
            end
          endcase
        end
      end
      ACT_TICK: begin
        if (copy_busy()) begin
          b = hist_mem[wr_pos - ofs_hold];
          put_history(b);
          copy_rem   = copy_rem - 16'd1;
          r.out_byte = b;
          r.status   = ST_BYTE;
        end else begin
          r.status = ST_IDLE;
        end
      end
      ACT_RESTART: begin
        clear_stream();
        r.status = ST_NONE;
      end
      default: r.status = ST_IDLE;
    endcase
    r.copy_pending = copy_busy();
    return r;
  endfunction

  // Mostly well-formed stream content, with some noise and stray beats
  function automatic in_item_t next_stream_beat(input bit deep, output bit counts);
    in_item_t    it;
    int unsigned r;
    int unsigned q;
    int unsigned top;
    it.action  = ACT_FEED;
    it.in_byte = 8'($urandom_range(0, 255));
    counts     = 1'b1;
    r          = $urandom_range(0, 999);
    if (r < 10) begin
      it.action = ACT_UNDEF;
      counts    = 1'b0;
    end else if (r < (deep ? 12 : 18)) begin
      it.action = ACT_RESTART;
    end else if (r < 60) begin
      it.action = ACT_TICK;
      counts    = copy_busy();
    end else if (copy_busy()) begin
      // a few feeds land on a running copy and get rejected
      if (r >= 90) it.action = ACT_TICK;
    end else if (grp_idx < 4'(GROUP_SIZE) && grp_flags[grp_idx[2:0]]) begin
      if (tok_idx == 2'd0) begin
        q   = $urandom_range(0, 99);
        top = (produced_cnt > 17'd65535) ? 65535 : int'(produced_cnt);
        if (q < 5) tok_ofs = 16'd0;
        else if (q < 10) tok_ofs = 16'(produced_cnt + 17'd1);
        else if (q < 15) tok_ofs = 16'($urandom_range(0, 65535));
        else if (top == 0) tok_ofs = 16'd1;
        else if (q < (deep ? 50 : 80)) tok_ofs = 16'($urandom_range(1, top < 16 ? top : 16));
        else tok_ofs = 16'($urandom_range(1, top));
        q = $urandom_range(0, 99);
        if (q < 5) tok_len = 16'd0;
        else if (q < 85) tok_len = 16'($urandom_range(1, 12));
        else if (q < 97) tok_len = 16'($urandom_range(13, 64));
        else tok_len = 16'($urandom_range(65, 400));
      end
      case (tok_idx)
        2'd0:    it.in_byte = tok_ofs[15:8];
        2'd1:    it.in_byte = tok_ofs[7:0];
        2'd2:    it.in_byte = tok_len[15:8];
        default: it.in_byte = tok_len[7:0];
      endcase
    end
    return it;
  endfunction

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one beat at the falling edge and hold it until accepted
  task automatic send_beat(input in_item_t it, input bit fixed, input out_item_t w);
    int gap;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = pick_gap(in_calm);
    exp_fixed = fixed;
    exp_want  = w;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (!in_taken);
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 127) == 0) out_calm = !out_calm;
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 99) < 20) stall_left = pick_gap(out_calm);
    out_ready <= (stall_left == 0);
  end

  // Result checking, then input acceptance and prediction
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (exp_cnt == 0) begin
        $error("unexpected result beat: out_byte %0h status %0d copy_pending %0b",
               out_data.out_byte, out_data.status, out_data.copy_pending);
        errors++;
      end else begin
        want    = exp_fifo[exp_rd];
        exp_rd  = (exp_rd + 1) % EXP_DEPTH;
        exp_cnt--;
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.copy_pending !== want.copy_pending) begin
          $error("copy_pending: expected %0b, got %0b", want.copy_pending,
                 out_data.copy_pending);
          errors++;
        end
      end
    end
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      pred = lzss_decode_beat(in_data);
      beats_in++;
      if (pred.status == ST_BAD_OFS) bad_ofs_cnt++;
      if (pred.status == ST_BUSY) busy_cnt++;
      if (in_data.action == ACT_TICK && pred.status == ST_BYTE) copy_bytes++;
      if (exp_cnt == EXP_DEPTH) begin
        $error("more than %0d result beats outstanding", EXP_DEPTH);
        errors++;
      end else begin
        exp_fifo[exp_wr] = exp_fixed ? exp_want : pred;
        exp_wr           = (exp_wr + 1) % EXP_DEPTH;
        exp_cnt++;
      end
    end
  end

  // Hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Directed rows; flag byte F2 gives literal, match, literal, literal, then matches
  dir_row_t dir_rows [NUM_DIR] = '{
    '{'{ACT_TICK,    8'h00}, 1'b1, '{8'h00, ST_IDLE,    1'b0}},  // tick with nothing to copy
    '{'{ACT_UNDEF,   8'hFF}, 1'b1, '{8'h00, ST_IDLE,    1'b0}},  // undefined action
    '{'{ACT_FEED,    8'hF2}, 1'b1, '{8'h00, ST_NONE,    1'b0}},  // flag byte
    '{'{ACT_FEED,    8'h00}, 1'b1, '{8'h00, ST_BYTE,    1'b0}},  // literal 00
    '{'{ACT_FEED,    8'h00}, 1'b1, '{8'h00, ST_NONE,    1'b0}},  // offset high
    '{'{ACT_TICK,    8'h00}, 1'b1, '{8'h00, ST_IDLE,    1'b0}},  // tick inside a token
    '{'{ACT_FEED,    8'h00}, 1'b1, '{8'h00, ST_NONE,    1'b0}},  // offset low: zero
    '{'{ACT_FEED,    8'hFF}, 1'b1, '{8'h00, ST_NONE,    1'b0}},  // length high
    '{'{ACT_FEED,    8'hFF}, 1'b1, '{8'h00, ST_BAD_OFS, 1'b0}},  // zero offset dropped
    '{'{ACT_FEED,    8'hFF}, 1'b1, '{8'hFF, ST_BYTE,    1'b0}},  // literal FF
    '{'{ACT_FEED,    8'h5A}, 1'b0, '{8'h00, ST_NONE,    1'b0}},  // literal 5A
    '{'{ACT_FEED,    8'hFF}, 1'b1, '{8'h00, ST_NONE,    1'b0}},  // offset FFFF
    '{'{ACT_FEED,    8'hFF}, 1'b1, '{8'h00, ST_NONE,    1'b0}},
    '{'{ACT_FEED,    8'h00}, 1'b1, '{8'h00, ST_NONE,    1'b0}},
    '{'{ACT_FEED,    8'h00}, 1'b1, '{8'h00, ST_BAD_OFS, 1'b0}},  // beyond produced bytes
    '{'{ACT_FEED,    8'h00}, 1'b0, '{8'h00, ST_NONE,    1'b0}},  // offset 3, length 0
    '{'{ACT_FEED,    8'h03}, 1'b0, '{8'h00, ST_NONE,    1'b0}},
    '{'{ACT_FEED,    8'h00}, 1'b0, '{8'h00, ST_NONE,    1'b0}},
    '{'{ACT_FEED,    8'h00}, 1'b0, '{8'h00, ST_NONE,    1'b0}},  // zero length, no copy
    '{'{ACT_FEED,    8'h00}, 1'b0, '{8'h00, ST_NONE,    1'b0}},  // offset 1, length FFFF
    '{'{ACT_FEED,    8'h01}, 1'b0, '{8'h00, ST_NONE,    1'b0}},
    '{'{ACT_FEED,    8'hFF}, 1'b0, '{8'h00, ST_NONE,    1'b0}},
    '{'{ACT_FEED,    8'hFF}, 1'b0, '{8'h00, ST_NONE,    1'b0}},  // overlapping copy starts
    '{'{ACT_TICK,    8'h00}, 1'b0, '{8'h00, ST_BYTE,    1'b0}},
    '{'{ACT_FEED,    8'h33}, 1'b1, '{8'h00, ST_BUSY,    1'b1}},  // feed during copy
    '{'{ACT_TICK,    8'h00}, 1'b0, '{8'h00, ST_BYTE,    1'b0}},
    '{'{ACT_RESTART, 8'h00}, 1'b1, '{8'h00, ST_NONE,    1'b0}},  // restart drops the copy
    '{'{ACT_TICK,    8'h00}, 1'b1, '{8'h00, ST_IDLE,    1'b0}}
  };

  // Stimulus sequence
  initial begin
    in_item_t it;
    bit       counts;
    int       counted;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    in_calm    = 1'b0;
    counted    = 0;
    clear_stream();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++)
      send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);

    // random streams over a short history
    while (counted < PHASE_A_BEATS) begin
      it = next_stream_beat(1'b0, counts);
      send_beat(it, 1'b0, '0);
      if (counts) counted++;
    end

    // three literals, then an overlapping copy of 64 bytes run to the end
    send_beat('{ACT_RESTART, 8'h00}, 1'b0, '0);
    send_beat('{ACT_FEED, 8'h08}, 1'b0, '0);
    repeat (3) send_beat('{ACT_FEED, 8'($urandom_range(0, 255))}, 1'b0, '0);
    send_beat('{ACT_FEED, 8'h00}, 1'b0, '0);
    send_beat('{ACT_FEED, 8'h03}, 1'b0, '0);
    send_beat('{ACT_FEED, 8'h00}, 1'b0, '0);
    send_beat('{ACT_FEED, 8'h40}, 1'b0, '0);
    while (copy_busy()) send_beat('{ACT_TICK, 8'($urandom_range(0, 255))}, 1'b0, '0);

    // random streams reaching further back
    while (counted < TOTAL_BEATS) begin
      it = next_stream_beat(1'b1, counts);
      send_beat(it, 1'b0, '0);
      if (counts) counted++;
    end
    in_valid <= 1'b0;

    while (exp_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result beats for %0d input beats: %0d copied bytes, %0d bad offsets,",
             results_seen, beats_in, copy_bytes, bad_ofs_cnt);
    $display("%0d feeds turned away while a copy was running", busy_cnt);
    if (errors == 0 && exp_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
